[rtl/arm_pkg.sv]
// Shared types, codes and constants for the axis rotation matrix block.
package arm_pkg;

    // Entry format: signed Q1.(ENTRY_WIDTH-2).
    localparam int ENTRY_WIDTH = 16;
    localparam int FRAC_BITS   = ENTRY_WIDTH - 2;
    localparam int MAG_W       = ENTRY_WIDTH - 1;
    localparam int ROUND_SHIFT = 32 - FRAC_BITS;

    // Angle input: degrees with 8 fractional bits, so a full turn is 360 * 256 units.
    localparam int ANGLE_W       = 24;
    localparam int TURN_LOW_BITS = 11;
    localparam int TURN_ODD      = 45;
    localparam int FULL_TURN     = TURN_ODD << TURN_LOW_BITS;
    localparam int QUARTER_TURN  = FULL_TURN / 4;
    localparam int EIGHTH_TURN   = FULL_TURN / 8;
    // Offset that the sign-bit flip adds, taken modulo a full turn.
    localparam int TURN_BIAS     = (1 << (ANGLE_W - 1)) % FULL_TURN;

    // Reciprocal of the odd factor of a full turn, exact for all high parts.
    localparam int HIGH_W          = ANGLE_W - TURN_LOW_BITS;
    localparam int ODD_RECIP_SHIFT = 19;
    localparam int ODD_RECIP       = ((1 << ODD_RECIP_SHIFT) + TURN_ODD - 1) / TURN_ODD;
    localparam int ODD_RECIP_W     = 14;
    localparam int PROD1_W         = HIGH_W + ODD_RECIP_W;
    localparam int QUOT_W          = PROD1_W - ODD_RECIP_SHIFT;
    localparam int REM_W           = 6;
    localparam int TURN_W          = REM_W + TURN_LOW_BITS;
    localparam int FRAC_W          = 15;
    localparam int OCT_W           = 14;

    // One angle unit in radians, Q0.32.
    localparam int RAD_PER_UNIT = 292818;
    localparam int RAD_W        = 19;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Horner steps; each divides by a constant through an exact reciprocal.
    localparam int NUM_STEPS = 4;
    localparam int STEP_W    = 2;

    // Sine divisors 72, 42, 20, 6.
    localparam logic [32:0] SIN_RECIP [NUM_STEPS] = '{
        33'(((65'd1 << 39) + 65'd71) / 65'd72),
        33'(((65'd1 << 38) + 65'd41) / 65'd42),
        33'(((65'd1 << 37) + 65'd19) / 65'd20),
        33'(((65'd1 << 35) + 65'd5) / 65'd6)
    };
    localparam logic [5:0] SIN_SHIFT [NUM_STEPS] = '{6'd39, 6'd38, 6'd37, 6'd35};

    // Cosine divisors 90, 56, 30, 12.
    localparam logic [32:0] COS_RECIP [NUM_STEPS] = '{
        33'(((65'd1 << 39) + 65'd89) / 65'd90),
        33'(((65'd1 << 38) + 65'd55) / 65'd56),
        33'(((65'd1 << 37) + 65'd29) / 65'd30),
        33'(((65'd1 << 36) + 65'd11) / 65'd12)
    };
    localparam logic [5:0] COS_SHIFT [NUM_STEPS] = '{6'd39, 6'd38, 6'd37, 6'd36};

    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_BAD = 2'd3
    } t_axis;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef logic signed [ENTRY_WIDTH-1:0] t_entry;
    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_deg;
        t_axis                     axis;
    } t_in_item;

    typedef struct packed {
        t_entry m00;
        t_entry m01;
        t_entry m02;
        t_entry m10;
        t_entry m11;
        t_entry m12;
        t_entry m20;
        t_entry m21;
        t_entry m22;
        logic   bad_axis;
    } t_out_item;

    // Work carried along the polynomial chain.
    typedef struct packed {
        t_axis       axis;
        t_quad       quad;
        logic        swap;
        logic [31:0] x;
        logic [31:0] x2;
        logic [32:0] ts;
        logic [32:0] tc;
    } t_lane;

endpackage

[rtl/arm_if.sv]
// Valid/ready channel interfaces for the input and result items.
interface arm_in_if;
    import arm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface arm_out_if;
    import arm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/arm_front.sv]
// Angle reduction: wrap to one turn, fold to an octant, scale to radians, square.
module arm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  arm_pkg::t_in_item i_item,
    output logic              o_vld,
    input  logic              i_rdy,
    output arm_pkg::t_lane    o_lane
);
    import arm_pkg::*;

    localparam int NS = 5;

    logic [NS-1:0] r_vld;
    logic [NS:0]   stage_rdy;
    logic [NS-1:0] vld_in;

    // Stage registers.
    logic [HIGH_W-1:0]        r1_hi;
    logic [TURN_LOW_BITS-1:0] r1_lo;
    logic [QUOT_W-1:0]        r1_quot;
    t_axis                    r1_axis;
    logic [TURN_W-1:0]        r2_turn;
    t_axis                    r2_axis;
    logic [OCT_W-1:0]         r3_g;
    t_quad                    r3_quad;
    logic                     r3_swap;
    t_axis                    r3_axis;
    logic [31:0]              r4_x;
    t_quad                    r4_quad;
    logic                     r4_swap;
    t_axis                    r4_axis;
    t_lane                    r5_lane;

    // Next values.
    logic [ANGLE_W-1:0]    n_biased;
    logic [PROD1_W-1:0]    n_prod1;
    logic [HIGH_W-1:0]     n_rem_full;
    logic [TURN_W-1:0]     n_turn_raw;
    logic [TURN_W-1:0]     n_turn;
    logic [FRAC_W-1:0]     n_frac;
    t_quad                 n_quad;
    logic [OCT_W-1:0]      n_g;
    logic                  n_swap;
    logic [OCT_W+RAD_W-1:0] n_prod4;
    logic [63:0]           n_prod5;

    // Per-stage load enables: a stage loads when empty or when its successor moves.
    always_comb begin
        stage_rdy[NS] = i_rdy;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    assign vld_in = {r_vld[NS-2:0], i_vld};
    assign o_rdy  = stage_rdy[0];
    assign o_vld  = r_vld[NS-1];
    assign o_lane = r5_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    // Stage 1: flip the sign bit and estimate the high part divided by the odd factor.
    always_comb begin
        n_biased = {~i_item.angle_deg[ANGLE_W-1], i_item.angle_deg[ANGLE_W-2:0]};
        n_prod1  = PROD1_W'(n_biased[ANGLE_W-1:TURN_LOW_BITS]) * PROD1_W'(ODD_RECIP);
    end

    // Stage 2: remainder of a full turn, then remove the bias of the sign flip.
    always_comb begin
        n_rem_full = r1_hi - HIGH_W'(HIGH_W'(r1_quot) * HIGH_W'(TURN_ODD));
        n_turn_raw = {n_rem_full[REM_W-1:0], r1_lo};
        if (n_turn_raw >= TURN_W'(TURN_BIAS)) begin
            n_turn = n_turn_raw - TURN_W'(TURN_BIAS);
        end else begin
            n_turn = n_turn_raw + TURN_W'(FULL_TURN - TURN_BIAS);
        end
    end

    // Stage 3: quadrant, offset within it, and fold of the upper octant.
    always_comb begin
        if (r2_turn < TURN_W'(QUARTER_TURN)) begin
            n_quad = QUAD_0;
            n_frac = FRAC_W'(r2_turn);
        end else if (r2_turn < TURN_W'(2 * QUARTER_TURN)) begin
            n_quad = QUAD_1;
            n_frac = FRAC_W'(r2_turn - TURN_W'(QUARTER_TURN));
        end else if (r2_turn < TURN_W'(3 * QUARTER_TURN)) begin
            n_quad = QUAD_2;
            n_frac = FRAC_W'(r2_turn - TURN_W'(2 * QUARTER_TURN));
        end else begin
            n_quad = QUAD_3;
            n_frac = FRAC_W'(r2_turn - TURN_W'(3 * QUARTER_TURN));
        end
        if (n_frac > FRAC_W'(EIGHTH_TURN)) begin
            n_swap = 1'b1;
            n_g    = OCT_W'(FRAC_W'(QUARTER_TURN) - n_frac);
        end else begin
            n_swap = 1'b0;
            n_g    = OCT_W'(n_frac);
        end
    end

    // Stages 4 and 5: radians in Q0.32 and their square.
    always_comb begin
        n_prod4 = (OCT_W+RAD_W)'(r3_g) * (OCT_W+RAD_W)'(RAD_PER_UNIT);
        n_prod5 = {32'd0, r4_x} * {32'd0, r4_x};
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r1_hi   <= n_biased[ANGLE_W-1:TURN_LOW_BITS];
            r1_lo   <= n_biased[TURN_LOW_BITS-1:0];
            r1_quot <= n_prod1[PROD1_W-1:ODD_RECIP_SHIFT];
            r1_axis <= i_item.axis;
        end
        if (stage_rdy[1]) begin
            r2_turn <= n_turn;
            r2_axis <= r1_axis;
        end
        if (stage_rdy[2]) begin
            r3_g    <= n_g;
            r3_quad <= n_quad;
            r3_swap <= n_swap;
            r3_axis <= r2_axis;
        end
        if (stage_rdy[3]) begin
            r4_x    <= n_prod4[31:0];
            r4_quad <= r3_quad;
            r4_swap <= r3_swap;
            r4_axis <= r3_axis;
        end
        if (stage_rdy[4]) begin
            r5_lane.axis <= r4_axis;
            r5_lane.quad <= r4_quad;
            r5_lane.swap <= r4_swap;
            r5_lane.x    <= r4_x;
            r5_lane.x2   <= n_prod5[63:32];
            r5_lane.ts   <= ONE_Q32;
            r5_lane.tc   <= ONE_Q32;
        end
    end

endmodule

[rtl/arm_cell.sv]
// One Horner step for sine and cosine: t = 1 - x2 * t / d, two pipeline stages.
module arm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [arm_pkg::STEP_W-1:0] i_step,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  arm_pkg::t_lane             i_lane,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output arm_pkg::t_lane             o_lane
);
    import arm_pkg::*;

    logic  [1:0] r_vld;
    logic  [2:0] stage_rdy;

    t_lane       r_a_lane;
    logic [31:0] r_a_ps;
    logic [31:0] r_a_pc;
    t_lane       r_b_lane;

    logic [64:0] n_prod_s;
    logic [64:0] n_prod_c;
    logic [64:0] n_quo_s;
    logic [64:0] n_quo_c;
    t_lane       n_lane;

    // Local handshake for the two stages.
    assign stage_rdy[2] = i_rdy;
    assign stage_rdy[1] = !r_vld[1] || stage_rdy[2];
    assign stage_rdy[0] = !r_vld[0] || stage_rdy[1];
    assign o_rdy        = stage_rdy[0];
    assign o_vld        = r_vld[1];
    assign o_lane       = r_b_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            if (stage_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // Stage A: products of x2 with the running terms, Q0.32.
    always_comb begin
        n_prod_s = {33'd0, i_lane.x2} * {32'd0, i_lane.ts};
        n_prod_c = {33'd0, i_lane.x2} * {32'd0, i_lane.tc};
    end

    // Stage B: truncating division by the step's divisor through its reciprocal.
    always_comb begin
        n_quo_s   = ({33'd0, r_a_ps} * {32'd0, SIN_RECIP[i_step]}) >> SIN_SHIFT[i_step];
        n_quo_c   = ({33'd0, r_a_pc} * {32'd0, COS_RECIP[i_step]}) >> COS_SHIFT[i_step];
        n_lane    = r_a_lane;
        n_lane.ts = ONE_Q32 - {1'b0, n_quo_s[31:0]};
        n_lane.tc = ONE_Q32 - {1'b0, n_quo_c[31:0]};
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r_a_lane <= i_lane;
            r_a_ps   <= n_prod_s[63:32];
            r_a_pc   <= n_prod_c[63:32];
        end
        if (stage_rdy[1]) begin
            r_b_lane <= n_lane;
        end
    end

endmodule

[rtl/arm_matrix.sv]
// Final sine and cosine terms, rounding to entry format, quadrant unfold and matrix layout.
module arm_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  arm_pkg::t_lane     i_lane,
    output logic               o_vld,
    input  logic               i_rdy,
    output arm_pkg::t_out_item o_item
);
    import arm_pkg::*;

    logic [2:0] r_vld;
    logic [3:0] stage_rdy;

    t_axis       r1_axis;
    t_quad       r1_quad;
    logic        r1_swap;
    logic [31:0] r1_sin;
    logic [31:0] r1_cprod;
    t_axis       r2_axis;
    t_quad       r2_quad;
    logic        r2_swap;
    t_mag        r2_sin;
    t_mag        r2_cos;
    t_out_item   r3_item;

    logic [63:0] n_prod_s;
    logic [63:0] n_prod_c;
    logic [32:0] n_cos_q32;
    logic [32:0] n_sum_s;
    logic [32:0] n_sum_c;
    t_mag        n_ps;
    t_mag        n_pc;
    t_entry      n_pos_s;
    t_entry      n_pos_c;
    t_entry      n_s;
    t_entry      n_c;
    t_entry      n_one;
    t_out_item   n_item;

    always_comb begin
        stage_rdy[3] = i_rdy;
        for (int k = 2; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    assign o_rdy  = stage_rdy[0];
    assign o_vld  = r_vld[2];
    assign o_item = r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            if (stage_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (stage_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    // Stage 1: sine is x times its term; cosine needs x2 times its term.
    always_comb begin
        n_prod_s = {32'd0, i_lane.x} * {31'd0, i_lane.ts};
        n_prod_c = {32'd0, i_lane.x2} * {31'd0, i_lane.tc};
    end

    // Stage 2: last cosine step, then round half up to the entry format.
    always_comb begin
        n_cos_q32 = ONE_Q32 - {2'b00, r1_cprod[31:1]};
        n_sum_s   = {1'b0, r1_sin} + 33'(1 << (ROUND_SHIFT - 1));
        n_sum_c   = n_cos_q32 + 33'(1 << (ROUND_SHIFT - 1));
    end

    // Stage 3: undo the octant fold and the quadrant, then place the entries.
    always_comb begin
        n_ps    = r2_swap ? r2_cos : r2_sin;
        n_pc    = r2_swap ? r2_sin : r2_cos;
        n_pos_s = t_entry'({1'b0, n_ps});
        n_pos_c = t_entry'({1'b0, n_pc});
        n_one   = t_entry'(1 << FRAC_BITS);
        unique case (r2_quad)
            QUAD_0: begin
                n_s = n_pos_s;
                n_c = n_pos_c;
            end
            QUAD_1: begin
                n_s = n_pos_c;
                n_c = -n_pos_s;
            end
            QUAD_2: begin
                n_s = -n_pos_s;
                n_c = -n_pos_c;
            end
            QUAD_3: begin
                n_s = -n_pos_c;
                n_c = n_pos_s;
            end
            default: begin
                n_s = n_pos_s;
                n_c = n_pos_c;
            end
        endcase

        n_item = '0;
        unique case (r2_axis)
            AXIS_X: begin
                n_item.m00 = n_one;
                n_item.m11 = n_c;
                n_item.m12 = -n_s;
                n_item.m21 = n_s;
                n_item.m22 = n_c;
            end
            AXIS_Y: begin
                n_item.m00 = n_c;
                n_item.m02 = n_s;
                n_item.m11 = n_one;
                n_item.m20 = -n_s;
                n_item.m22 = n_c;
            end
            AXIS_Z: begin
                n_item.m00 = n_c;
                n_item.m01 = -n_s;
                n_item.m10 = n_s;
                n_item.m11 = n_c;
                n_item.m22 = n_one;
            end
            default: begin
                n_item.bad_axis = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r1_axis  <= i_lane.axis;
            r1_quad  <= i_lane.quad;
            r1_swap  <= i_lane.swap;
            r1_sin   <= n_prod_s[63:32];
            r1_cprod <= n_prod_c[63:32];
        end
        if (stage_rdy[1]) begin
            r2_axis <= r1_axis;
            r2_quad <= r1_quad;
            r2_swap <= r1_swap;
            r2_sin  <= n_sum_s[32:ROUND_SHIFT];
            r2_cos  <= n_sum_c[32:ROUND_SHIFT];
        end
        if (stage_rdy[2]) begin
            r3_item <= n_item;
        end
    end

endmodule

[rtl/axis_rotation_matrix.sv]
// Top level: 3x3 rotation matrix about the x, y or z axis for an angle in degrees.
//
//   Port    Dir   Handshake     Item
//   i_in    in    valid/ready   angle_deg (24 b signed, 1/256 deg), axis (2 b)
//   o_out   out   valid/ready   m00..m22 (16 b signed Q1.14), bad_axis (1 b)
//
// One item per cycle sustained while the output is ready; a result passes through the
// angle reduction stages, each Horner cell in a row of 4, and the finishing stages.
// Every stage has its own valid bit and loads when empty or when its successor moves,
// so bubbles close up and new items enter while a result waits at the output.
// A stalled output holds its item; synchronous reset clears only the valid bits.
module axis_rotation_matrix (
    input  logic      i_clk,
    input  logic      i_rst_n,
    arm_in_if.sink    i_in,
    arm_out_if.source o_out
);
    import arm_pkg::*;

    logic [NUM_STEPS:0] chain_vld;
    logic [NUM_STEPS:0] chain_rdy;
    t_lane              chain_lane [NUM_STEPS+1];

    // Angle reduction, radians and square.
    arm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_item  (i_in.data),
        .o_vld   (chain_vld[0]),
        .i_rdy   (chain_rdy[0]),
        .o_lane  (chain_lane[0])
    );

    // Row of Horner cells, one polynomial step each.
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
        arm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_W'(k)),
            .i_vld   (chain_vld[k]),
            .o_rdy   (chain_rdy[k]),
            .i_lane  (chain_lane[k]),
            .o_vld   (chain_vld[k+1]),
            .i_rdy   (chain_rdy[k+1]),
            .o_lane  (chain_lane[k+1])
        );
    end

    // Final terms, rounding and matrix layout into the output register.
    arm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (chain_vld[NUM_STEPS]),
        .o_rdy   (chain_rdy[NUM_STEPS]),
        .i_lane  (chain_lane[NUM_STEPS]),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_item  (o_out.data)
    );

endmodule

[test/tb_axis_rotation_matrix.sv]
// Self-checking testbench for the axis rotation matrix block, with a bit-exact matrix predictor.
module tb_axis_rotation_matrix;
    import arm_pkg::*;

    // Angle units are 1/256 degree.
    localparam int TURN_UNITS    = 92160;
    localparam int QUARTER_UNITS = 23040;
    localparam int EIGHTH_UNITS  = 11520;
    localparam logic [63:0] RAD_Q32   = 64'd292818;
    localparam logic [63:0] UNITY_Q32 = 64'h1_0000_0000;
    localparam int Q_SHIFT = 18;

    localparam t_entry E1 = 16'sd16384;
    localparam t_entry E0 = 16'sd0;

    localparam int IDLE_PCT      = 15;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 60000;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item want;
    } t_vector;

    logic i_clk;
    logic i_rst_n;

    arm_in_if  in_if ();
    arm_out_if out_if ();

    axis_rotation_matrix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_out_item pending_matrices[$];
    t_vector   vectors[$];
    int        cycle_count = 0;
    int        mismatches  = 0;
    int        matrices_seen = 0;
    int        directed_sent = 0;
    int        random_sent   = 0;
    int        bad_axis_sent = 0;
    bit        steady = 1'b0;

    // Clock: period 10.
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q0.32 product, truncated as in the fixed-point datapath.
    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 32;
    endfunction

    // Round half up from Q0.32 to the Q1.14 entry format.
    function automatic int q32_to_entry(input logic [63:0] v);
        return int'((v + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT);
    endfunction

    // Sine and cosine of g units within the first octant, by Horner-form Taylor series.
    function automatic void octant_sin_cos(input int unsigned g, output int sn, output int cs);
        logic [63:0] x, x2, t;
        x  = 64'(g) * RAD_Q32;
        x2 = q32_mul(x, x);

        t = UNITY_Q32 - x2 / 72;
        t = UNITY_Q32 - q32_mul(x2, t) / 42;
        t = UNITY_Q32 - q32_mul(x2, t) / 20;
        t = UNITY_Q32 - q32_mul(x2, t) / 6;
        sn = q32_to_entry(q32_mul(x, t));

        t = UNITY_Q32 - x2 / 90;
        t = UNITY_Q32 - q32_mul(x2, t) / 56;
        t = UNITY_Q32 - q32_mul(x2, t) / 30;
        t = UNITY_Q32 - q32_mul(x2, t) / 12;
        cs = q32_to_entry(UNITY_Q32 - q32_mul(x2, t) / 2);
    endfunction

    // Expected rotation matrix for one input item.
    function automatic t_out_item rotation_of(input t_in_item it);
        int          a, r, s, c, ps, pc;
        int unsigned f;
        t_quad       q;
        t_out_item   m;
        m = '0;
        if (it.axis == AXIS_BAD) begin
            m.bad_axis = 1'b1;
            return m;
        end

        // Wrap into one turn, then fold into the first octant.
        a = it.angle_deg;
        r = a % TURN_UNITS;
        if (r < 0) begin
            r += TURN_UNITS;
        end
        q = t_quad'(r / QUARTER_UNITS);
        f = r % QUARTER_UNITS;
        if (f > EIGHTH_UNITS) begin
            octant_sin_cos(QUARTER_UNITS - f, pc, ps);
        end else begin
            octant_sin_cos(f, ps, pc);
        end

        case (q)
            QUAD_0: begin s = ps;  c = pc;  end
            QUAD_1: begin s = pc;  c = -ps; end
            QUAD_2: begin s = -ps; c = -pc; end
            default: begin s = -pc; c = ps; end
        endcase

        case (it.axis)
            AXIS_X: begin
                m.m00 = E1;
                m.m11 = t_entry'(c);
                m.m12 = t_entry'(-s);
                m.m21 = t_entry'(s);
                m.m22 = t_entry'(c);
            end
            AXIS_Y: begin
                m.m00 = t_entry'(c);
                m.m02 = t_entry'(s);
                m.m11 = E1;
                m.m20 = t_entry'(-s);
                m.m22 = t_entry'(c);
            end
            default: begin
                m.m00 = t_entry'(c);
                m.m01 = t_entry'(-s);
                m.m10 = t_entry'(s);
                m.m11 = t_entry'(c);
                m.m22 = E1;
            end
        endcase
        return m;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Compare one result against the oldest expected matrix, entry by entry.
    task automatic check_matrix(input t_out_item got, input t_out_item want);
        t_entry g[9];
        t_entry w[9];
        g = '{got.m00, got.m01, got.m02, got.m10, got.m11, got.m12, got.m20, got.m21, got.m22};
        w = '{want.m00, want.m01, want.m02, want.m10, want.m11, want.m12,
              want.m20, want.m21, want.m22};
        for (int i = 0; i < 9; i++) begin
            if (g[i] !== w[i]) begin
                report_mismatch($sformatf("result %0d m%0d%0d got %0d, wanted %0d",
                                          matrices_seen, i / 3, i % 3, g[i], w[i]));
            end
        end
        if (got.bad_axis !== want.bad_axis) begin
            report_mismatch($sformatf("result %0d bad_axis got %0b, wanted %0b",
                                      matrices_seen, got.bad_axis, want.bad_axis));
        end
    endtask

    task automatic add_vec(input int angle, input t_axis ax, input bit fixed = 1'b0,
                           input t_out_item want = '0);
        t_vector v;
        v.item.angle_deg = 24'(angle);
        v.item.axis      = ax;
        v.fixed          = fixed;
        v.want           = want;
        vectors.push_back(v);
    endtask

    // Offer one item, with random idle cycles first outside the steady stretch, and hold it until accepted.
    task automatic send_item(input t_in_item it, input t_out_item want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        pending_matrices.push_back(want);
        if (it.axis == AXIS_BAD) begin
            bad_axis_sent++;
        end
    endtask

    // Result side: random stalls except during the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_matrices.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          matrices_seen));
            end else begin
                check_matrix(out_if.data, pending_matrices.pop_front());
            end
            matrices_seen++;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_matrices.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: directed table, then random items.
    initial begin
        t_in_item it;
        int       angle;
        int       kind;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;

        // Zero angle gives the identity on every axis.
        add_vec(0, AXIS_X, 1'b1, '{E1, E0, E0, E0, E1, E0, E0, E0, E1, 1'b0});
        add_vec(0, AXIS_Y, 1'b1, '{E1, E0, E0, E0, E1, E0, E0, E0, E1, 1'b0});
        add_vec(0, AXIS_Z, 1'b1, '{E1, E0, E0, E0, E1, E0, E0, E0, E1, 1'b0});
        // A quarter turn on each axis.
        add_vec(QUARTER_UNITS, AXIS_X, 1'b1, '{E1, E0, E0, E0, E0, -E1, E0, E1, E0, 1'b0});
        add_vec(QUARTER_UNITS, AXIS_Y, 1'b1, '{E0, E0, E1, E0, E1, E0, -E1, E0, E0, 1'b0});
        add_vec(QUARTER_UNITS, AXIS_Z, 1'b1, '{E0, -E1, E0, E1, E0, E0, E0, E0, E1, 1'b0});
        // Invalid axis code zeroes the matrix whatever the angle.
        add_vec(8388607, AXIS_BAD, 1'b1, '{E0, E0, E0, E0, E0, E0, E0, E0, E0, 1'b1});
        add_vec(-8388608, AXIS_BAD, 1'b1, '{E0, E0, E0, E0, E0, E0, E0, E0, E0, 1'b1});
        add_vec(0, AXIS_BAD, 1'b1, '{E0, E0, E0, E0, E0, E0, E0, E0, E0, 1'b1});
        // Half turn: the sine comes out as negative zero and must read as zero.
        add_vec(2 * QUARTER_UNITS, AXIS_Z, 1'b1,
                '{-E1, E0, E0, E0, -E1, E0, E0, E0, E1, 1'b0});
        // Whole turns wrap back to the identity.
        add_vec(TURN_UNITS, AXIS_Z, 1'b1, '{E1, E0, E0, E0, E1, E0, E0, E0, E1, 1'b0});
        add_vec(-TURN_UNITS, AXIS_Y, 1'b1, '{E1, E0, E0, E0, E1, E0, E0, E0, E1, 1'b0});
        // Angle extremes, quadrant and octant boundaries and small angles go through the predictor.
        add_vec(8388607, AXIS_X);
        add_vec(8388607, AXIS_Y);
        add_vec(8388607, AXIS_Z);
        add_vec(-8388608, AXIS_X);
        add_vec(-8388608, AXIS_Y);
        add_vec(-8388608, AXIS_Z);
        add_vec(3 * QUARTER_UNITS, AXIS_Y);
        add_vec(-QUARTER_UNITS, AXIS_X);
        add_vec(EIGHTH_UNITS, AXIS_Z);
        add_vec(EIGHTH_UNITS + 1, AXIS_Z);
        add_vec(1, AXIS_X);
        add_vec(-1, AXIS_Y);
        add_vec(TURN_UNITS - 1, AXIS_Z);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[i]) begin
            send_item(vectors[i].item,
                      vectors[i].fixed ? vectors[i].want : rotation_of(vectors[i].item));
            directed_sent++;
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // No idling on either side through the middle of the random run.
            steady = (n >= 400 && n < 600);
            kind = $urandom_range(99);
            if (kind < 60) begin
                angle = int'($urandom);
            end else if (kind < 85) begin
                angle = int'($urandom_range(4 * TURN_UNITS)) - 2 * TURN_UNITS;
            end else begin
                // Near quadrant and octant boundaries, either sign.
                angle = int'($urandom_range(15)) * EIGHTH_UNITS - 3 + int'($urandom_range(6));
                if ($urandom_range(1)) begin
                    angle = -angle;
                end
            end
            it.angle_deg = 24'(angle);
            it.axis = ($urandom_range(99) < 10) ? AXIS_BAD : t_axis'($urandom_range(2));
            send_item(it, rotation_of(it));
            random_sent++;
        end
        steady = 1'b0;
        in_if.valid <= 1'b0;

        // Drain the pipeline, then allow a few more cycles for stray results.
        while (pending_matrices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d directed and %0d random items, %0d with an invalid axis code.",
                 directed_sent, random_sent, bad_axis_sent);
        $display("Checked %0d matrices in %0d cycles, %0d mismatches.",
                 matrices_seen, cycle_count, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
